>>> hdl/svg_pkg.sv
// Shared types and constants for the sphere vertex generator.
package svg_pkg;

  localparam int IDX_W    = 11;
  localparam int CNT_W    = 11;
  localparam int RAD_W    = 16;
  localparam int TEX_W    = 17;
  localparam int POS_W    = 17;
  localparam int NORM_W   = 16;
  localparam int PHASE_W  = 32;
  localparam int TRIG_W   = 34;
  localparam int DIV_LAT  = 32;
  localparam int ATAN_N   = 24;

  localparam logic [CNT_W-1:0] RST_STACK  = 11'd16;
  localparam logic [CNT_W-1:0] RST_SECTOR = 11'd32;
  localparam logic [RAD_W-1:0] RST_RADIUS = 16'd256;

  // 0.6072529350 in Q2.30
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // atan(2^-k) as a fraction of a turn, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_STACK  = 2'd1,
    REG_SECTOR = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             err;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } side_t;

endpackage

>>> hdl/sphere_vertex_generator.sv
// UV sphere vertex generator: position, normal and texture coordinates per index pair.
// One vertex word is taken per cycle and results leave in order through one entry
// stage, 32 stages of the bit-per-stage long dividers that turn indices into angle
// phases, a phase stage, CORDIC_STAGES + 1 stages of each CORDIC, then product,
// rounding, radius-multiply and output stages. When the output word is not taken
// the whole pipeline holds and in_ready drops in the same cycle.
module sphere_vertex_generator #(
  parameter int MAX_COUNT     = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [svg_pkg::IDX_W-1:0]           in_stack_index,
  input  logic [svg_pkg::IDX_W-1:0]           in_sector_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [svg_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [svg_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [svg_pkg::POS_W-1:0]    out_pos_z,
  output logic signed [svg_pkg::NORM_W-1:0]   out_norm_x,
  output logic signed [svg_pkg::NORM_W-1:0]   out_norm_y,
  output logic signed [svg_pkg::NORM_W-1:0]   out_norm_z,
  output logic [svg_pkg::TEX_W-1:0]           out_tex_u,
  output logic [svg_pkg::TEX_W-1:0]           out_tex_v,
  output logic                                out_index_error,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import svg_pkg::*;

  localparam int CNT_CAP  = (MAX_COUNT > 2047) ? 2047 : MAX_COUNT;
  localparam int SIDE_N   = CORDIC_STAGES + 4;
  localparam int PIPE_LAT = CORDIC_STAGES + 39;
  localparam int VW       = TRIG_W;

  // ---------------- configuration ----------------
  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] stack_cnt_r, sector_cnt_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RST_RADIUS;
      stack_cnt_r  <= RST_STACK;
      sector_cnt_r <= RST_SECTOR;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_RADIUS: radius_r     <= pwdata[RAD_W-1:0];
        REG_STACK:  stack_cnt_r  <= pwdata[CNT_W-1:0];
        REG_SECTOR: sector_cnt_r <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_RADIUS: prdata = 32'(radius_r);
      REG_STACK:  prdata = 32'(stack_cnt_r);
      REG_SECTOR: prdata = 32'(sector_cnt_r);
      default:    prdata = '0;
    endcase
  end

  logic [CNT_W-1:0] scnt, tcnt;
  always_comb begin
    if (stack_cnt_r == '0)                scnt = CNT_W'(1);
    else if (32'(stack_cnt_r) > CNT_CAP)  scnt = CNT_W'(CNT_CAP);
    else                                  scnt = stack_cnt_r;
    if (sector_cnt_r == '0)               tcnt = CNT_W'(1);
    else if (32'(sector_cnt_r) > CNT_CAP) tcnt = CNT_W'(CNT_CAP);
    else                                  tcnt = sector_cnt_r;
  end

  // ---------------- flow control ----------------
  logic                adv;
  logic [PIPE_LAT-1:0] v_r;

  assign adv       = ~v_r[PIPE_LAT-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // ---------------- entry: clamp indices ----------------
  logic [IDX_W-1:0] i_e_r, j_e_r;
  logic             err_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      i_e_r   <= (in_stack_index > scnt) ? scnt : in_stack_index;
      j_e_r   <= (in_sector_index > tcnt) ? tcnt : in_sector_index;
      err_e_r <= (in_stack_index > scnt) | (in_sector_index > tcnt);
    end
  end

  // ---------------- phase dividers ----------------
  logic [31:0]      quo_stack;
  logic [32:0]      quo_sector;
  logic [TEX_W-1:0] tex_v_d, tex_u_d;
  logic             err_d_r [DIV_LAT];

  svg_frac_div #(.FRAC_BITS(31), .LAT(DIV_LAT)) u_div_stack (
    .clk (clk), .en (adv), .num (i_e_r), .div (scnt),
    .quo (quo_stack), .tex (tex_v_d)
  );

  svg_frac_div #(.FRAC_BITS(32), .LAT(DIV_LAT)) u_div_sector (
    .clk (clk), .en (adv), .num (j_e_r), .div (tcnt),
    .quo (quo_sector), .tex (tex_u_d)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      err_d_r[0] <= err_e_r;
      for (int s = 1; s < DIV_LAT; s++) err_d_r[s] <= err_d_r[s-1];
    end
  end

  logic [PHASE_W-1:0] ph_stack_r, ph_sector_r;
  side_t              side_p_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_stack_r     <= 32'h4000_0000 - quo_stack;
      ph_sector_r    <= quo_sector[PHASE_W-1:0];
      side_p_r.err   <= err_d_r[DIV_LAT-1];
      side_p_r.tex_u <= tex_u_d;
      side_p_r.tex_v <= tex_v_d;
    end
  end

  // ---------------- trig ----------------
  logic signed [TRIG_W-1:0] cp, sp, ct, st;

  svg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_stack (
    .clk (clk), .en (adv), .phase (ph_stack_r), .cos_o (cp), .sin_o (sp)
  );

  svg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_sector (
    .clk (clk), .en (adv), .phase (ph_sector_r), .cos_o (ct), .sin_o (st)
  );

  side_t side_r [SIDE_N];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_p_r;
      for (int s = 1; s < SIDE_N; s++) side_r[s] <= side_r[s-1];
    end
  end

  // ---------------- normal products ----------------
  logic signed [2*TRIG_W-1:0] pxx_r, pxy_r;
  logic signed [TRIG_W-1:0]   sp_m_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxx_r  <= cp * ct;
      pxy_r  <= cp * st;
      sp_m_r <= sp;
    end
  end

  logic signed [2*TRIG_W-1:0] rxx, rxy;
  logic signed [VW-1:0]       nx_r, ny_r, nz_r;
  assign rxx = (pxx_r + (2*TRIG_W)'(64'sh2000_0000)) >>> 30;
  assign rxy = (pxy_r + (2*TRIG_W)'(64'sh2000_0000)) >>> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= rxx[VW-1:0];
      ny_r <= rxy[VW-1:0];
      nz_r <= sp_m_r;
    end
  end

  // ---------------- radius multiply and Q1.14 normal ----------------
  localparam int PW = RAD_W + 1 + VW;

  logic signed [PW-1:0]     px_r, py_r, pz_r;
  logic signed [NORM_W-1:0] nqx_r, nqy_r, nqz_r;
  logic signed [RAD_W:0]    rad_s;

  assign rad_s = $signed({1'b0, radius_r});

  function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + VW'(32768)) >>> 16;
    if (r < -VW'(16384))     sat_norm = -NORM_W'(16384);
    else if (r > VW'(16384)) sat_norm = NORM_W'(16384);
    else                     sat_norm = r[NORM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= rad_s * nx_r;
      py_r  <= rad_s * ny_r;
      pz_r  <= rad_s * nz_r;
      nqx_r <= sat_norm(nx_r);
      nqy_r <= sat_norm(ny_r);
      nqz_r <= sat_norm(nz_r);
    end
  end

  // ---------------- position rounding and output word ----------------
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + PW'(32'sh2000_0000)) >>> 30;
    if (r < -PW'(65535))     sat_pos = -POS_W'(65535);
    else if (r > PW'(65535)) sat_pos = POS_W'(65535);
    else                     sat_pos = r[POS_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_x       <= sat_pos(px_r);
      out_pos_y       <= sat_pos(py_r);
      out_pos_z       <= sat_pos(pz_r);
      out_norm_x      <= nqx_r;
      out_norm_y      <= nqy_r;
      out_norm_z      <= nqz_r;
      out_tex_u       <= side_r[SIDE_N-1].tex_u;
      out_tex_v       <= side_r[SIDE_N-1].tex_v;
      out_index_error <= side_r[SIDE_N-1].err;
    end
  end

  // ---------------- assertions ----------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(v_r))
    else $error("pipeline valids moved during a stall");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_u <= 17'd65536) && (out_tex_v <= 17'd65536))
    else $error("texture coordinate above one");

  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (radius_r == '0) |->
      (out_pos_x == '0) && (out_pos_y == '0) && (out_pos_z == '0))
    else $error("nonzero position with zero radius");

endmodule

>>> hdl/svg_frac_div.sv
// Pipelined long divider: rounded num*2^FRAC_BITS/div, one quotient bit per stage.
module svg_frac_div #(
  parameter int FRAC_BITS = 32,
  parameter int LAT       = 32
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [svg_pkg::IDX_W-1:0]           num,
  input  logic [svg_pkg::CNT_W-1:0]           div,
  output logic [FRAC_BITS:0]                  quo,
  output logic [svg_pkg::TEX_W-1:0]           tex
);
  import svg_pkg::*;

  localparam int TEX_TAP = TEX_W - 1;

  logic [CNT_W-1:0]   rem_r   [LAT];
  logic [FRAC_BITS:0] q_r     [LAT];
  logic [TEX_W-1:0]   tex_r   [LAT];
  logic [CNT_W-1:0]   rem_nxt [LAT];
  logic [FRAC_BITS:0] q_nxt   [LAT];
  logic [TEX_W-1:0]   tex_nxt [LAT];
  logic [CNT_W-1:0]   half;

  assign half = div >> 1;

  always_comb begin
    logic [CNT_W-1:0]   rem_in;
    logic [FRAC_BITS:0] q_in;
    logic [CNT_W:0]     dbl;
    logic               ge;
    logic               rb;
    for (int s = 0; s < LAT; s++) begin
      if (s == 0) begin
        // num never exceeds div, so the integer bit is num == div
        q_in   = (FRAC_BITS+1)'(num == div);
        rem_in = (num == div) ? '0 : num;
      end else begin
        q_in   = q_r[s-1];
        rem_in = rem_r[s-1];
      end
      dbl = {rem_in, 1'b0};
      ge  = dbl >= {1'b0, div};
      if (s < FRAC_BITS) begin
        rem_nxt[s] = ge ? CNT_W'(dbl - {1'b0, div}) : dbl[CNT_W-1:0];
        q_nxt[s]   = {q_in[FRAC_BITS-1:0], ge};
      end else begin
        rem_nxt[s] = rem_in;
        q_nxt[s]   = q_in;
      end
      if (s == TEX_TAP) begin
        rb         = ({1'b0, rem_r[s-1]} + {1'b0, half}) >= {1'b0, div};
        tex_nxt[s] = TEX_W'(q_r[s-1][TEX_W-1:0] + TEX_W'(rb));
      end else if (s > TEX_TAP) begin
        tex_nxt[s] = tex_r[s-1];
      end else begin
        tex_nxt[s] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < LAT; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        tex_r[s] <= tex_nxt[s];
      end
    end
  end

  logic rb_last;
  assign rb_last = ({1'b0, rem_r[LAT-1]} + {1'b0, half}) >= {1'b0, div};
  assign quo     = q_r[LAT-1] + (FRAC_BITS+1)'(rb_last);
  assign tex     = tex_r[LAT-1];

endmodule

>>> hdl/svg_cordic.sv
// Pipelined rotation CORDIC: cosine and sine in signed Q3.30 of a 32-bit turn phase.
module svg_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [svg_pkg::PHASE_W-1:0]           phase,
  output logic signed [svg_pkg::TRIG_W-1:0]     cos_o,
  output logic signed [svg_pkg::TRIG_W-1:0]     sin_o
);
  import svg_pkg::*;

  localparam int ZW = 33;

  logic signed [TRIG_W-1:0] x_r [STAGES];
  logic signed [TRIG_W-1:0] y_r [STAGES];
  logic signed [ZW-1:0]     z_r [STAGES];
  logic [1:0]               qd_r [STAGES];
  logic signed [TRIG_W-1:0] x_nxt [STAGES];
  logic signed [TRIG_W-1:0] y_nxt [STAGES];
  logic signed [ZW-1:0]     z_nxt [STAGES];
  logic [1:0]               qd_nxt [STAGES];
  logic [PHASE_W-1:0]       p;

  assign p = phase + 32'h2000_0000;

  always_comb begin
    logic signed [TRIG_W-1:0] xi, yi, dx, dy;
    logic signed [ZW-1:0]     zi, at;
    logic [1:0]               qi;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        xi = $signed({2'b00, CORDIC_GAIN});
        yi = '0;
        zi = $signed({3'b000, p[29:0]}) - $signed(ZW'(32'h2000_0000));
        qi = p[31:30];
      end else begin
        xi = x_r[s-1];
        yi = y_r[s-1];
        zi = z_r[s-1];
        qi = qd_r[s-1];
      end
      dx = yi >>> s;
      dy = xi >>> s;
      at = $signed({1'b0, ATAN_TURNS[s]});
      if (zi >= 0) begin
        x_nxt[s] = xi - dx;
        y_nxt[s] = yi + dy;
        z_nxt[s] = zi - at;
      end else begin
        x_nxt[s] = xi + dx;
        y_nxt[s] = yi - dy;
        z_nxt[s] = zi + at;
      end
      qd_nxt[s] = qi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        x_r[s]  <= x_nxt[s];
        y_r[s]  <= y_nxt[s];
        z_r[s]  <= z_nxt[s];
        qd_r[s] <= qd_nxt[s];
      end
    end
  end

  logic signed [TRIG_W-1:0] c_nxt, s_nxt, xl, yl;
  assign xl = x_r[STAGES-1];
  assign yl = y_r[STAGES-1];

  // quadrant unfold
  always_comb begin
    unique case (qd_r[STAGES-1])
      2'd0:    begin c_nxt = xl;  s_nxt = yl;  end
      2'd1:    begin c_nxt = -yl; s_nxt = xl;  end
      2'd2:    begin c_nxt = -xl; s_nxt = -yl; end
      default: begin c_nxt = yl;  s_nxt = -xl; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= c_nxt;
      sin_o <= s_nxt;
    end
  end

endmodule
